@@ rtl/core/rtd_pkg.sv @@
// Shared types and constants for the rest time detector.
`timescale 1ns / 1ps

package rtd_pkg;

  localparam int unsigned TICK_MS_DEFAULT = 100;

  localparam int unsigned HOUR_W      = 5;
  localparam int unsigned MINUTE_W    = 6;
  localparam int unsigned CURRENT_W   = 16;
  localparam int unsigned THRESHOLD_W = 15;
  localparam int unsigned REST_HRS_W  = 5;
  localparam int unsigned CNT_W       = 10;
  localparam int unsigned STAMP_W     = 13;
  localparam int unsigned ELAPSED_W   = 14;

  localparam int unsigned QUIET_MS = 10000;
  localparam int unsigned BUSY_MS  = 2000;
  localparam int unsigned MS_PER_S = 1000;

  localparam logic [CNT_W-1:0]       CNT_MAX         = '1;
  localparam logic [ELAPSED_W-1:0]   DAY_PACKED      = ELAPSED_W'(24 * 256);
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(50);
  localparam logic [REST_HRS_W-1:0]  REST_HRS_RESET  = REST_HRS_W'(12);

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  typedef enum logic {
    REG_CURRENT_THRESHOLD = 1'b0,
    REG_REST_HOURS        = 1'b1
  } rtd_reg_e;

  typedef struct packed {
    logic [THRESHOLD_W-1:0] current_threshold;
    logic [REST_HRS_W-1:0]  rest_hours;
  } rtd_cfg_t;

endpackage

@@ rtl/core/rtd_if.sv @@
// Valid/ready channel interfaces for sample words and result words.
`timescale 1ns / 1ps

interface rtd_in_if
  import rtd_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [HOUR_W-1:0]           hour;
  logic [MINUTE_W-1:0]         minute;
  logic signed [CURRENT_W-1:0] current;

  modport source (output valid, hour, minute, current, input ready);
  modport sink (input valid, hour, minute, current, output ready);
endinterface

interface rtd_out_if;
  logic valid;
  logic ready;
  logic rest_done;

  modport source (output valid, rest_done, input ready);
  modport sink (input valid, rest_done, output ready);
endinterface

@@ rtl/core/rtd_apb_regs.sv @@
// APB configuration registers: current threshold and required rest hours.
`timescale 1ns / 1ps

module rtd_apb_regs
  import rtd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output rtd_cfg_t              cfg_o
);

  rtd_cfg_t cfg_q, cfg_d;
  rtd_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = rtd_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_CURRENT_THRESHOLD: cfg_d.current_threshold = pwdata[THRESHOLD_W-1:0];
        REG_REST_HOURS:        cfg_d.rest_hours        = pwdata[REST_HRS_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CURRENT_THRESHOLD: prdata = APB_DATA_W'(cfg_q.current_threshold);
      REG_REST_HOURS:        prdata = APB_DATA_W'(cfg_q.rest_hours);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_threshold <= THRESHOLD_RESET;
      cfg_q.rest_hours        <= REST_HRS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/rtd_rest_core.sv @@
// Sample register, quiet/busy qualification state and result register.
`timescale 1ns / 1ps

module rtd_rest_core
  import rtd_pkg::*;
#(
  parameter int unsigned TICK_MS = TICK_MS_DEFAULT
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rtd_cfg_t cfg_i,
  rtd_in_if.sink   in_i,
  rtd_out_if.source out_o
);

  // Tick counts at which the quiet and busy conditions are met, and reload values.
  localparam logic [CNT_W-1:0] QUIET_TICKS  = CNT_W'((QUIET_MS + TICK_MS - 1) / TICK_MS);
  localparam logic [CNT_W-1:0] BUSY_TICKS   = CNT_W'((BUSY_MS + TICK_MS - 1) / TICK_MS);
  localparam logic [CNT_W-1:0] QUIET_RELOAD = CNT_W'(QUIET_MS / TICK_MS);
  localparam logic [CNT_W-1:0] BUSY_RELOAD  = CNT_W'(BUSY_MS / TICK_MS);

  // Sample register.
  logic                        s1_valid_q;
  logic [HOUR_W-1:0]           hour_q;
  logic [MINUTE_W-1:0]         minute_q;
  logic signed [CURRENT_W-1:0] current_q;

  // Qualification state.
  logic [CNT_W-1:0]   quiet_count_q, quiet_count_d;
  logic [CNT_W-1:0]   busy_count_q, busy_count_d;
  logic               stamp_taken_q, stamp_taken_d;
  logic [STAMP_W-1:0] start_stamp_q, start_stamp_d;

  // Result register.
  logic s2_valid_q;
  logic rest_done_q, rest_done_d;

  logic                   advance, in_fire, step;
  logic [CURRENT_W:0]     mag;
  logic                   quiet;
  logic [CNT_W-1:0]       quiet_inc, busy_inc;
  logic                   quiet_hit, busy_hit;
  logic [STAMP_W-1:0]     now;
  logic [ELAPSED_W-1:0]   elapsed;
  logic [ELAPSED_W-1:0]   rest_limit;

  assign advance    = ~s2_valid_q | out_o.ready;
  assign in_i.ready = ~s1_valid_q | advance;
  assign in_fire    = in_i.valid & in_i.ready;
  assign step       = s1_valid_q & advance;

  always_comb begin
    if (current_q[CURRENT_W-1]) begin
      mag = (CURRENT_W+1)'(1 << CURRENT_W) - {1'b0, current_q};
    end else begin
      mag = {1'b0, current_q};
    end
  end

  assign quiet      = mag < (CURRENT_W+1)'(cfg_i.current_threshold);
  assign quiet_inc  = (quiet_count_q == CNT_MAX) ? CNT_MAX : quiet_count_q + 1'b1;
  assign busy_inc   = (busy_count_q == CNT_MAX) ? CNT_MAX : busy_count_q + 1'b1;
  assign quiet_hit  = quiet_inc >= QUIET_TICKS;
  assign busy_hit   = busy_inc >= BUSY_TICKS;
  assign now        = {hour_q, 2'b00, minute_q};
  assign rest_limit = ELAPSED_W'({cfg_i.rest_hours, 8'h00});

  // The packed elapsed time wraps at midnight when the clock reads earlier than the stamp.
  always_comb begin
    if (now >= start_stamp_q) begin
      elapsed = ELAPSED_W'(now) - ELAPSED_W'(start_stamp_q);
    end else begin
      elapsed = DAY_PACKED + ELAPSED_W'(now) - ELAPSED_W'(start_stamp_q);
    end
  end

  always_comb begin
    quiet_count_d = quiet_count_q;
    busy_count_d  = busy_count_q;
    stamp_taken_d = stamp_taken_q;
    start_stamp_d = start_stamp_q;
    rest_done_d   = 1'b0;
    if (quiet) begin
      quiet_count_d = quiet_inc;
      if (quiet_hit) begin
        busy_count_d  = '0;
        quiet_count_d = QUIET_RELOAD;
        if (!stamp_taken_q) begin
          stamp_taken_d = 1'b1;
          start_stamp_d = now;
        end else begin
          rest_done_d = elapsed >= rest_limit;
        end
      end
    end else begin
      busy_count_d = busy_inc;
      if (busy_hit) begin
        quiet_count_d = '0;
        busy_count_d  = BUSY_RELOAD;
        stamp_taken_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      quiet_count_q <= '0;
      busy_count_q  <= '0;
      stamp_taken_q <= 1'b0;
      start_stamp_q <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        s2_valid_q <= s1_valid_q;
      end
      if (step) begin
        quiet_count_q <= quiet_count_d;
        busy_count_q  <= busy_count_d;
        stamp_taken_q <= stamp_taken_d;
        start_stamp_q <= start_stamp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hour_q    <= in_i.hour;
      minute_q  <= in_i.minute;
      current_q <= in_i.current;
    end
    if (step) begin
      rest_done_q <= rest_done_d;
    end
  end

  assign out_o.valid     = s2_valid_q;
  assign out_o.rest_done = rest_done_q;

  a_busy_drops_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !quiet && busy_hit |=> !stamp_taken_q && quiet_count_q == '0)
    else $error("busy qualification did not drop the stamp");

  a_done_needs_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && rest_done_d |-> stamp_taken_q && quiet && quiet_hit)
    else $error("rest_done raised without a qualified stamp");

  a_stamp_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(start_stamp_q) && $stable(stamp_taken_q) && $stable(quiet_count_q))
    else $error("qualification state changed without a word");

  a_quiet_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && quiet && quiet_hit |=> busy_count_q == '0 && stamp_taken_q)
    else $error("quiet qualification did not clear the busy count");

endmodule

@@ rtl/core/rest_time_detector.sv @@
// Rest time detector: a word enters the sample register and its result word leaves
// from the result register. Throughput is one word per cycle when the output is not
// stalled; the qualification state updates in the single stage between the two
// registers. Reset is asynchronous and active low: it clears both counters and the
// stamp flag and loads threshold 50 and rest hours 12.
`timescale 1ns / 1ps

module rest_time_detector
  import rtd_pkg::*;
#(
  parameter int unsigned TICK_MS = TICK_MS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  rtd_in_if.sink                in_i,
  rtd_out_if.source             out_o
);

  rtd_cfg_t cfg;

  rtd_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rtd_rest_core #(
    .TICK_MS (TICK_MS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

@@ sim/rtd_checker.sv @@
// Result checker for the rest time detector: predicts each result word and compares it.
`timescale 1ns / 1ps

module rtd_checker
  import rtd_pkg::*;
#(
  parameter int unsigned TICK_MS = TICK_MS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  rtd_in_if                     in_mon,
  rtd_out_if                    out_mon,
  output int                    mismatch_cnt_o,
  output int                    open_cnt_o
);

  // Shadow of the configuration registers.
  logic [THRESHOLD_W-1:0] threshold;
  logic [REST_HRS_W-1:0]  rest_hrs;

  // Shadow of the qualification state.
  logic [CNT_W-1:0]   quiet_cnt;
  logic [CNT_W-1:0]   busy_cnt;
  logic               stamp_valid;
  logic [STAMP_W-1:0] stamp;

  logic rest_done_q[$];
  logic want_done;

  initial begin
    mismatch_cnt_o = 0;
    open_cnt_o     = 0;
  end

  function automatic logic next_rest_done(input logic [HOUR_W-1:0] hour,
                                          input logic [MINUTE_W-1:0] minute,
                                          input logic signed [CURRENT_W-1:0] current);
    int          mag;
    int          now_packed;
    logic [31:0] elapsed;
    logic        done;
    done = 1'b0;
    // The magnitude of the most negative current is 32768 and is never quiet.
    mag = (current < 0) ? -int'(current) : int'(current);
    if (mag < int'(threshold)) begin
      if (quiet_cnt != CNT_MAX) quiet_cnt = quiet_cnt + 1'b1;
      if (int'(quiet_cnt) * int'(TICK_MS) >= int'(QUIET_MS)) begin
        now_packed = int'(hour) * 256 + int'(minute);
        busy_cnt   = '0;
        quiet_cnt  = CNT_W'(QUIET_MS / TICK_MS);
        if (!stamp_valid) begin
          stamp_valid = 1'b1;
          stamp       = STAMP_W'(now_packed);
        end else begin
          // An out-of-range stamp can push the wrapped difference below zero; it
          // then wraps to a huge unsigned value, as 32-bit unsigned arithmetic does.
          if (now_packed >= int'(stamp)) elapsed = now_packed - int'(stamp);
          else elapsed = int'(DAY_PACKED) + now_packed - int'(stamp);
          done = (elapsed >= {19'b0, rest_hrs, 8'h00});
        end
      end
    end else begin
      if (busy_cnt != CNT_MAX) busy_cnt = busy_cnt + 1'b1;
      if (int'(busy_cnt) * int'(TICK_MS) >= int'(BUSY_MS)) begin
        quiet_cnt   = '0;
        busy_cnt    = CNT_W'(BUSY_MS / TICK_MS);
        stamp_valid = 1'b0;
      end
    end
    return done;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold   = THRESHOLD_RESET;
      rest_hrs    = REST_HRS_RESET;
      quiet_cnt   = '0;
      busy_cnt    = '0;
      stamp_valid = 1'b0;
      stamp       = '0;
      rest_done_q.delete();
      open_cnt_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (rtd_reg_e'(paddr[2]))
          REG_CURRENT_THRESHOLD: threshold = pwdata[THRESHOLD_W-1:0];
          REG_REST_HOURS:        rest_hrs  = pwdata[REST_HRS_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        rest_done_q.push_back(next_rest_done(in_mon.hour, in_mon.minute, in_mon.current));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (rest_done_q.size() == 0) begin
          $error("unexpected result word: rest_done %0b", out_mon.rest_done);
          mismatch_cnt_o++;
        end else begin
          want_done = rest_done_q.pop_front();
          if (want_done !== out_mon.rest_done) begin
            $error("rest_done mismatch: expected %0b, actual %0b", want_done,
                   out_mon.rest_done);
            mismatch_cnt_o++;
          end
        end
      end
      open_cnt_o = rest_done_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the rest time detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import rtd_pkg::*;

  localparam int unsigned NUM_SEGS      = 8;
  localparam int unsigned SEG_ITEMS     = 192;
  localparam int unsigned PRESSURE_SEG  = 1;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam time         RUN_LIMIT     = 5_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_cnt;
  int open_cnt;

  // seg_idx and stall_pct are shared with the receiver; all three are written only by the stimulus.
  int unsigned seg_idx   = 0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  int unsigned tb_threshold;
  int unsigned sent;
  int unsigned run_len;
  int unsigned kind;
  bit          held = 1'b0;

  rtd_in_if  in_ch ();
  rtd_out_if out_ch ();

  rest_time_detector dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  rtd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .open_cnt_o     (open_cnt)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Result receiver. Once, in the pressure segment, it holds off for a long
  // stretch so the block fills up and stalls its input.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (seg_idx == PRESSURE_SEG && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
    end
  end

  task automatic reg_write(input rtd_reg_e idx, input logic [APB_DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CURRENT_THRESHOLD) tb_threshold = val[THRESHOLD_W-1:0];
  endtask

  task automatic send_sample(input logic [HOUR_W-1:0] hour, input logic [MINUTE_W-1:0] minute,
                             input logic signed [CURRENT_W-1:0] current);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.hour    <= hour;
    in_ch.minute  <= minute;
    in_ch.current <= current;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  // Mostly real clock readings, sometimes raw bit patterns out of range.
  task automatic pick_clock(output logic [HOUR_W-1:0] hour, output logic [MINUTE_W-1:0] minute);
    if ($urandom_range(99) < 85) begin
      hour   = HOUR_W'($urandom_range(23));
      minute = MINUTE_W'($urandom_range(59));
    end else begin
      hour   = HOUR_W'($urandom());
      minute = MINUTE_W'($urandom());
    end
  endtask

  function automatic logic signed [CURRENT_W-1:0] quiet_current(input int unsigned limit);
    int mag;
    mag = int'($urandom_range(limit - 1, 0));
    return $urandom_range(1) ? CURRENT_W'(-mag) : CURRENT_W'(mag);
  endfunction

  function automatic logic signed [CURRENT_W-1:0] busy_current(input int unsigned limit);
    int mag;
    mag = int'($urandom_range(32768, limit));
    if (mag == 32768) return 16'sh8000;
    return $urandom_range(1) ? CURRENT_W'(-mag) : CURRENT_W'(mag);
  endfunction

  task automatic send_run(input int unsigned count, input int unsigned what);
    logic [HOUR_W-1:0]           hour;
    logic [MINUTE_W-1:0]         minute;
    logic signed [CURRENT_W-1:0] current;
    // The last run of a segment is cut so the segment ends at its word count.
    if (count > SEG_ITEMS - sent) count = SEG_ITEMS - sent;
    for (int unsigned i = 0; i < count; i++) begin
      pick_clock(hour, minute);
      case (what)
        0:       current = quiet_current(tb_threshold);
        1:       current = busy_current(tb_threshold);
        default: current = CURRENT_W'($urandom());
      endcase
      send_sample(hour, minute, current);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (open_cnt == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.hour    = '0;
    in_ch.minute  = '0;
    in_ch.current = '0;
    tb_threshold  = THRESHOLD_RESET;
    sent          = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes with the widest quiet band; only full scale currents of
    // either sign and the most negative current are busy here.
    reg_write(REG_CURRENT_THRESHOLD, 32'd32767);
    reg_write(REG_REST_HOURS, 32'd0);
    send_sample(5'd0, 6'd0, 16'sh8000);
    send_sample(5'd23, 6'd59, 16'sh7fff);
    send_sample(5'd31, 6'd63, -16'sd32767);
    send_sample(5'd24, 6'd60, 16'sd0);
    send_sample(5'd0, 6'd59, -16'sd1);
    send_sample(5'd23, 6'd0, 16'sd1);
    send_sample(5'd16, 6'd32, 16'sh5555);
    send_sample(5'd15, 6'd31, 16'shaaaa);
    send_sample(5'd31, 6'd0, 16'sh7ffe);
    drain();
    // A zero threshold makes every word busy, even zero current.
    reg_write(REG_CURRENT_THRESHOLD, 32'd0);
    reg_write(REG_REST_HOURS, 32'd31);
    send_sample(5'd0, 6'd0, 16'sd0);
    send_sample(5'd1, 6'd1, -16'sd1);
    send_sample(5'd31, 6'd63, 16'sh8000);
    send_sample(5'd12, 6'd30, 16'sd1);
    drain();

    for (int unsigned s = 0; s < NUM_SEGS; s++) begin
      case (s)
        0: begin reg_write(REG_CURRENT_THRESHOLD, 32'd50);
                 reg_write(REG_REST_HOURS, 32'd12); end
        1: begin reg_write(REG_CURRENT_THRESHOLD, 32'd32767);
                 reg_write(REG_REST_HOURS, 32'd0); end
        2: begin reg_write(REG_CURRENT_THRESHOLD, 32'd1);
                 reg_write(REG_REST_HOURS, 32'd31); end
        3: begin reg_write(REG_CURRENT_THRESHOLD, $urandom_range(32767, 1));
                 reg_write(REG_REST_HOURS, 32'd24); end
        4: begin reg_write(REG_CURRENT_THRESHOLD, $urandom_range(32767, 1));
                 reg_write(REG_REST_HOURS, $urandom_range(31)); end
        5: begin reg_write(REG_CURRENT_THRESHOLD, 32'd2000);
                 reg_write(REG_REST_HOURS, 32'd1); end
        6: begin reg_write(REG_CURRENT_THRESHOLD, $urandom_range(32767, 1));
                 reg_write(REG_REST_HOURS, 32'd25); end
        default: begin reg_write(REG_CURRENT_THRESHOLD, 32'd50);
                       reg_write(REG_REST_HOURS, $urandom_range(6)); end
      endcase
      case (s / 2)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 76; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      seg_idx = s;
      sent    = 0;
      // Long quiet runs reach qualification and the stamp; busy bursts either
      // side of the clearing length test whether the latch survives.
      while (sent < SEG_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 55) begin
          run_len = $urandom_range(140, 20);
          send_run(run_len, 0);
        end else if (kind < 80) begin
          run_len = $urandom_range(28, 1);
          send_run(run_len, 1);
        end else if (kind < 90) begin
          run_len = $urandom_range(10, 1);
          send_run(run_len, 0);
        end else begin
          run_len = $urandom_range(6, 1);
          send_run(run_len, 2);
        end
      end
      drain();
    end

    if (mismatch_cnt == 0 && open_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
